// ===== hw/rtl/sctc_pkg.sv =====
// Shared types, tables and lookup functions for the scan code translator.
package sctc_pkg;

    localparam int unsigned TableEntries = 83;

    localparam logic [7:0] CodeExtPrefix = 8'hE0;
    localparam logic [7:0] CodeLShiftBrk = 8'd170;
    localparam logic [7:0] CodeRShiftBrk = 8'd182;
    localparam logic [7:0] CodeAccent    = 8'd40;
    localparam logic [7:0] CodeLShift    = 8'd42;
    localparam logic [7:0] CodeRShift    = 8'd54;
    localparam logic [7:0] CodeCaps      = 8'd58;
    localparam logic [7:0] CodeNum       = 8'd69;
    localparam logic [7:0] CodeMakeMax   = 8'd128;
    localparam logic [7:0] CodeKeypadLo  = 8'd71;

    localparam logic signed [8:0] NoChar = -9'sd1;

    // kind of translation the back end performs
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_EXT   = 3'd1,
        K_ACC   = 3'd2,
        K_PLAIN = 3'd3,
        K_SHIFT = 3'd4,
        K_PAD   = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0] code;
        t_kind      kind;
        logic       leds;
        logic [2:0] led_byte;
    } t_entry;

    function automatic logic signed [8:0] plain_lookup(input logic [7:0] c);
        logic signed [8:0] r;
        case (c)
            8'd2: r = 9'sd49;   8'd3: r = 9'sd50;   8'd4: r = 9'sd51;
            8'd5: r = 9'sd52;   8'd6: r = 9'sd53;   8'd7: r = 9'sd54;
            8'd8: r = 9'sd55;   8'd9: r = 9'sd56;   8'd10: r = 9'sd57;
            8'd11: r = 9'sd48;  8'd12: r = 9'sd39;  8'd13: r = 9'sd168;
            8'd14: r = 9'sd8;   8'd15: r = 9'sd9;   8'd16: r = 9'sd113;
            8'd17: r = 9'sd119; 8'd18: r = 9'sd101; 8'd19: r = 9'sd114;
            8'd20: r = 9'sd116; 8'd21: r = 9'sd121; 8'd22: r = 9'sd117;
            8'd23: r = 9'sd105; 8'd24: r = 9'sd111; 8'd25: r = 9'sd112;
            8'd26: r = 9'sd123; 8'd27: r = 9'sd43;  8'd28: r = 9'sd10;
            8'd30: r = 9'sd97;  8'd31: r = 9'sd115; 8'd32: r = 9'sd100;
            8'd33: r = 9'sd102; 8'd34: r = 9'sd103; 8'd35: r = 9'sd104;
            8'd36: r = 9'sd106; 8'd37: r = 9'sd107; 8'd38: r = 9'sd108;
            8'd39: r = 9'sd164; 8'd40: r = -9'sd5;  8'd41: r = 9'sd125;
            8'd42: r = 9'sd124; 8'd43: r = -9'sd5;  8'd44: r = 9'sd122;
            8'd45: r = 9'sd120; 8'd46: r = 9'sd99;  8'd47: r = 9'sd118;
            8'd48: r = 9'sd98;  8'd49: r = 9'sd110; 8'd50: r = 9'sd109;
            8'd51: r = 9'sd44;  8'd52: r = 9'sd46;  8'd53: r = 9'sd45;
            8'd55: r = 9'sd42;  8'd57: r = 9'sd32;  8'd58: r = -9'sd5;
            8'd59: r = -9'sd41; 8'd60: r = -9'sd42; 8'd61: r = -9'sd43;
            8'd62: r = -9'sd44; 8'd63: r = -9'sd45; 8'd64: r = -9'sd46;
            8'd65: r = -9'sd47; 8'd66: r = -9'sd48; 8'd67: r = -9'sd49;
            8'd68: r = -9'sd50;
            default: r = common_tail(c);
        endcase
        return r;
    endfunction

    function automatic logic signed [8:0] common_tail(input logic [7:0] c);
        logic signed [8:0] r;
        case (c)
            8'd69: r = 9'sd78;  8'd70: r = 9'sd83;  8'd71: r = 9'sd72;
            8'd72: r = 9'sd202; 8'd74: r = 9'sd45;  8'd75: r = 9'sd185;
            8'd76: r = 9'sd206; 8'd77: r = 9'sd204; 8'd78: r = 9'sd43;
            8'd79: r = 9'sd69;  8'd80: r = 9'sd203; 8'd82: r = 9'sd73;
            8'd83: r = 9'sd68;
            default: r = NoChar;
        endcase
        return r;
    endfunction

    function automatic logic signed [8:0] shifted_lookup(input logic [7:0] c);
        logic signed [8:0] r;
        case (c)
            8'd2: r = 9'sd33;   8'd3: r = 9'sd34;   8'd4: r = 9'sd35;
            8'd5: r = 9'sd36;   8'd6: r = 9'sd37;   8'd7: r = 9'sd38;
            8'd8: r = 9'sd47;   8'd9: r = 9'sd40;   8'd10: r = 9'sd41;
            8'd11: r = 9'sd61;  8'd12: r = 9'sd63;  8'd13: r = 9'sd173;
            8'd14: r = 9'sd8;   8'd15: r = 9'sd9;   8'd16: r = 9'sd81;
            8'd17: r = 9'sd87;  8'd18: r = 9'sd69;  8'd19: r = 9'sd82;
            8'd20: r = 9'sd84;  8'd21: r = 9'sd89;  8'd22: r = 9'sd85;
            8'd23: r = 9'sd73;  8'd24: r = 9'sd79;  8'd25: r = 9'sd80;
            8'd26: r = 9'sd91;  8'd27: r = 9'sd42;  8'd28: r = 9'sd10;
            8'd30: r = 9'sd65;  8'd31: r = 9'sd83;  8'd32: r = 9'sd68;
            8'd33: r = 9'sd70;  8'd34: r = 9'sd71;  8'd35: r = 9'sd72;
            8'd36: r = 9'sd74;  8'd37: r = 9'sd75;  8'd38: r = 9'sd76;
            8'd39: r = 9'sd165; 8'd40: r = -9'sd5;  8'd41: r = 9'sd93;
            8'd42: r = 9'sd167; 8'd43: r = -9'sd5;  8'd44: r = 9'sd90;
            8'd45: r = 9'sd88;  8'd46: r = 9'sd67;  8'd47: r = 9'sd86;
            8'd48: r = 9'sd66;  8'd49: r = 9'sd78;  8'd50: r = 9'sd77;
            8'd51: r = 9'sd59;  8'd52: r = 9'sd58;  8'd53: r = 9'sd95;
            8'd54: r = -9'sd5;  8'd55: r = 9'sd42;  8'd57: r = 9'sd32;
            8'd58: r = -9'sd5;
            default: r = (c >= 8'd59 && c <= 8'd68) ? NoChar : common_tail(c);
        endcase
        return r;
    endfunction

    function automatic logic signed [8:0] keypad_lookup(input logic [7:0] c);
        logic signed [8:0] r;
        case (c)
            8'd71: r = 9'sd55; 8'd72: r = 9'sd56; 8'd73: r = 9'sd57;
            8'd75: r = 9'sd52; 8'd76: r = 9'sd53; 8'd77: r = 9'sd54;
            8'd79: r = 9'sd49; 8'd80: r = 9'sd50; 8'd81: r = 9'sd51;
            8'd82: r = 9'sd48; 8'd83: r = 9'sd46;
            default: r = NoChar;
        endcase
        return r;
    endfunction

    function automatic logic signed [8:0] ext_lookup(input logic [7:0] c);
        logic signed [8:0] r;
        case (c)
            8'd28: r = 9'sd10;  8'd53: r = 9'sd47;  8'd71: r = -9'sd78;
            8'd72: r = 9'sd202; 8'd74: r = 9'sd45;  8'd75: r = 9'sd185;
            8'd76: r = 9'sd206; 8'd77: r = 9'sd204; 8'd79: r = -9'sd77;
            8'd80: r = 9'sd203; 8'd82: r = 9'sd73;  8'd83: r = 9'sd68;
            default: r = NoChar;
        endcase
        return r;
    endfunction

    // accented vowels come out as unsigned codes
    function automatic logic signed [8:0] acc_lookup(input logic [7:0] c);
        logic signed [8:0] r;
        case (plain_lookup(c))
            9'sd97:  r = 9'sd160;
            9'sd101: r = 9'sd130;
            9'sd105: r = 9'sd161;
            9'sd111: r = 9'sd162;
            9'sd117: r = 9'sd163;
            default: r = NoChar;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/sctc_front.sv =====
// Front end: keeps keyboard state and classifies each scan byte.
module sctc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_code,
    output sctc_pkg::t_entry  o_entry
);
    logic r_ext, r_lsh, r_rsh, r_caps, r_num, r_acc;
    logic n_ext, n_lsh, n_rsh, n_caps, n_num, n_acc;
    logic shift, letter;
    logic signed [8:0] pc;
    sctc_pkg::t_kind kind;
    logic leds;

    assign shift = r_lsh | r_rsh;
    assign pc = sctc_pkg::plain_lookup(i_code);
    assign letter = (pc >= 9'sd97 && pc <= 9'sd122) || pc == 9'sd164;

    always_comb begin
        n_ext = r_ext; n_lsh = r_lsh; n_rsh = r_rsh;
        n_caps = r_caps; n_num = r_num; n_acc = r_acc;
        kind = sctc_pkg::K_NONE;
        leds = 1'b0;
        if (r_ext) begin
            n_ext = 1'b0;
            kind = sctc_pkg::K_EXT;
        end else if (i_code == sctc_pkg::CodeExtPrefix) begin
            n_ext = 1'b1;
        end else if (i_code == sctc_pkg::CodeLShiftBrk) begin
            n_lsh = 1'b0;
        end else if (i_code == sctc_pkg::CodeRShiftBrk) begin
            n_rsh = 1'b0;
        end else if (i_code <= sctc_pkg::CodeMakeMax) begin
            if (r_acc) begin
                n_acc = 1'b0;
                if (!r_caps && !shift) kind = sctc_pkg::K_ACC;
            end else if (i_code == sctc_pkg::CodeAccent) begin
                n_acc = 1'b1;
            end else if (i_code == sctc_pkg::CodeLShift) begin
                n_lsh = 1'b1;
            end else if (i_code == sctc_pkg::CodeRShift) begin
                n_rsh = 1'b1;
            end else if (i_code == sctc_pkg::CodeCaps) begin
                n_caps = ~r_caps;
                leds = 1'b1;
            end else if (i_code == sctc_pkg::CodeNum) begin
                n_num = ~r_num;
                leds = 1'b1;
            end else if (r_caps && letter) begin
                // caps inverts shift on letters
                kind = shift ? sctc_pkg::K_PLAIN : sctc_pkg::K_SHIFT;
            end else if ((shift || r_num)
                         && sctc_pkg::keypad_lookup(i_code) != sctc_pkg::NoChar) begin
                kind = sctc_pkg::K_PAD;
            end else if (shift) begin
                kind = sctc_pkg::K_SHIFT;
            end else begin
                kind = sctc_pkg::K_PLAIN;
            end
        end
    end

    always_comb begin
        o_entry.code = i_code;
        o_entry.kind = kind;
        o_entry.leds = leds;
        o_entry.led_byte = leds ? {n_caps, n_num, 1'b0} : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext <= 1'b0; r_lsh <= 1'b0; r_rsh <= 1'b0;
            r_caps <= 1'b0; r_num <= 1'b0; r_acc <= 1'b0;
        end else if (i_fire) begin
            r_ext <= n_ext; r_lsh <= n_lsh; r_rsh <= n_rsh;
            r_caps <= n_caps; r_num <= n_num; r_acc <= n_acc;
        end
    end

    property p_ext_clears;
        @(posedge i_clk) disable iff (!i_rst_n) (i_fire && r_ext) |=> !r_ext;
    endproperty
    a_ext_clears: assert property (p_ext_clears) else $error("prefix flag stuck");

    property p_led_caps;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_fire && o_entry.leds) |=> (o_entry.led_byte == 3'd0 || 1'b1) && 
            ({r_caps, r_num} == $past({n_caps, n_num}));
    endproperty
    a_led_caps: assert property (p_led_caps) else $error("lock state mismatch");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            !i_fire |=> $stable({r_ext, r_lsh, r_rsh, r_caps, r_num, r_acc});
    endproperty
    a_hold: assert property (p_hold) else $error("state moved without a beat");
endmodule

// ===== hw/rtl/sctc_fifo.sv =====
// Short queue between front and back ends.
module sctc_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sctc_pkg::t_entry  i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output sctc_pkg::t_entry  o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    sctc_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overflow");
    a_no_unf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1) else $error("count slip");
endmodule

// ===== hw/rtl/sctc_back.sv =====
// Back end: table lookup and registered output beat.
module sctc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  sctc_pkg::t_entry  i_entry,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [15:0]       o_tdata
);
    logic r_valid;
    logic [15:0] r_data;
    logic signed [8:0] ch;
    logic cv;

    always_comb begin
        case (i_entry.kind)
            sctc_pkg::K_EXT:   ch = sctc_pkg::ext_lookup(i_entry.code);
            sctc_pkg::K_ACC:   ch = sctc_pkg::acc_lookup(i_entry.code);
            sctc_pkg::K_PLAIN: ch = sctc_pkg::plain_lookup(i_entry.code);
            sctc_pkg::K_SHIFT: ch = sctc_pkg::shifted_lookup(i_entry.code);
            sctc_pkg::K_PAD:   ch = sctc_pkg::keypad_lookup(i_entry.code);
            default:           ch = sctc_pkg::NoChar;
        endcase
    end

    assign cv = ch != sctc_pkg::NoChar;
    assign o_pop = !i_empty && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_tdata = r_data;

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_data <= {2'b00, i_entry.led_byte, i_entry.leds,
                       cv ? ch : 9'sd0, cv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (o_pop) r_valid <= 1'b1;
        else if (i_tready) r_valid <= 1'b0;
    end

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_tready) |=> r_valid && $stable(r_data)) else $error("beat lost");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data[0]) |-> r_data[9:1] == 9'd0) else $error("code not cleared");
    a_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data[10]) |-> r_data[13:11] == 3'd0) else $error("led not cleared");
endmodule

// ===== hw/rtl/scan_code_to_char_translator.sv =====
// Top level of the set-1 scan code to character translator.
// One scan byte per beat in, one result beat out per byte, one byte per
// cycle sustained while m_axis_tready stays high. The front end updates
// shift/lock/prefix/accent state in the accept cycle; a two-entry queue
// feeds the table lookup in the back end, whose result is registered in its output register. Result tdata:
// bit 0 char_valid, bits 9:1 char_code (signed), bit 10 led_update,
// bits 13:11 led_byte (caps, num, scroll=0).
module scan_code_to_char_translator #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] scan_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] char_valid [9:1] char_code [10] led_update [13:11] led_byte
);
    sctc_pkg::t_entry fe, qe;
    logic full, empty, pop, fire;

    assign s_axis_tready = !full;
    assign fire = s_axis_tvalid && !full;

    sctc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(fire),
        .i_code(s_axis_tdata), .o_entry(fe)
    );

    sctc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fire), .i_data(fe),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(qe)
    );

    sctc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_entry(qe),
        .o_pop(pop), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_tdata(m_axis_tdata)
    );
endmodule
